### rtl/dpf_pkg.sv
// Shared types and constants for the duplicate packet filter.
// Used by the channel interfaces, the entry table, the top level and the checker.
// No dependencies.
package dpf_pkg;

    localparam int ENTRIES = 24;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam int ADDR_W  = 32;
    localparam int SEQ_W   = 8;
    localparam int KIND_W  = 8;
    localparam int LIFE_W  = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(100);

    typedef enum logic [2:0] {
        OUTCOME_OWN      = 3'd0,
        OUTCOME_INSERTED = 3'd1,
        OUTCOME_UPDATED  = 3'd2,
        OUTCOME_DUP      = 3'd3,
        OUTCOME_FULL     = 3'd4
    } outcome_t;

    typedef enum logic {
        REG_OWN_ADDR    = 1'b0,
        REG_LIFE_RELOAD = 1'b1
    } reg_idx_t;

    // Write controls from the sequencer to the entry table.
    typedef struct packed {
        logic              life_we;
        logic [LIFE_W-1:0] life_val;
        logic              tag_we;
        logic              addr_we;
    } dpf_wr_t;

    // One entry as read from the table.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [KIND_W-1:0] kind;
        logic [LIFE_W-1:0] life;
    } dpf_entry_t;

endpackage

### rtl/dpf_in_if.sv
// Packet header channel: valid/ready handshake carrying one header word.
// Depends on dpf_pkg.
interface dpf_in_if;
    import dpf_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] src_addr;
    logic [SEQ_W-1:0]  seq_number;
    logic [KIND_W-1:0] kind;

    modport source (output valid, src_addr, seq_number, kind, input ready);
    modport sink   (input valid, src_addr, seq_number, kind, output ready);
    modport monitor (input valid, ready, src_addr, seq_number, kind);
endinterface

### rtl/dpf_out_if.sv
// Result channel: valid/ready handshake carrying the filter verdict word.
// Depends on dpf_pkg.
interface dpf_out_if;
    import dpf_pkg::*;

    logic       valid;
    logic       ready;
    logic       is_duplicate;
    logic [2:0] outcome;

    modport source (output valid, is_duplicate, outcome, input ready);
    modport sink   (input valid, is_duplicate, outcome, output ready);
    modport monitor (input valid, ready, is_duplicate, outcome);
endinterface

### rtl/duplicate_packet_filter_unit.sv
// Duplicate packet filter, top level: walk sequencer, configuration registers, result register.
// A packet from the own address goes straight to the result register; any other walks the table
// (one entry compared per cycle, up to the first address match), is inserted into a free entry if
// none matched and one is free, then has its verdict registered. One packet at a time: the next is
// accepted in the cycle after the current result is registered.
// Reset is asynchronous, active low: all lifetimes free, own_addr 0, life_reload 100.
module duplicate_packet_filter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    dpf_in_if.sink                      pkt,
    dpf_out_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpf_pkg::PADDR_W-1:0] paddr,
    input  logic [dpf_pkg::PDATA_W-1:0] pwdata,
    output logic [dpf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import dpf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_INSERT,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              free_found_reg, free_found_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    outcome_t          pend_reg, pend_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_dup_reg, res_dup_next;
    outcome_t          res_outcome_reg, res_outcome_next;
    logic [ADDR_W-1:0] own_addr_reg;
    logic [LIFE_W-1:0] life_reload_reg;

    logic              cfg_we;
    logic              live, hit, tag_eq, free_here;
    logic [IDX_W-1:0]  tbl_idx;
    dpf_wr_t           tbl_wr;
    dpf_entry_t        tbl_rd;

    dpf_entry_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (tbl_idx),
        .wr      (tbl_wr),
        .wr_addr (addr_reg),
        .wr_seq  (seq_reg),
        .wr_kind (kind_reg),
        .rd      (tbl_rd)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg    <= '0;
            life_reload_reg <= LIFE_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_OWN_ADDR:    own_addr_reg    <= pwdata[ADDR_W-1:0];
                REG_LIFE_RELOAD: life_reload_reg <= pwdata[LIFE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_OWN_ADDR:    prdata = PDATA_W'(own_addr_reg);
            REG_LIFE_RELOAD: prdata = PDATA_W'(life_reload_reg);
            default:         prdata = '0;
        endcase
    end

    // Shared compare unit on the entry under the index.
    assign live      = (tbl_rd.life != '0);
    assign hit       = live && (tbl_rd.addr == addr_reg);
    assign tag_eq    = (tbl_rd.seq == seq_reg) && (tbl_rd.kind == kind_reg);
    // An entry whose lifetime is at most one is free once the walk has passed it.
    assign free_here = (tbl_rd.life <= LIFE_W'(1));

    assign tbl_idx = (state_reg == ST_INSERT) ? free_idx_reg : idx_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        free_idx_next    = free_idx_reg;
        free_found_next  = free_found_reg;
        addr_next        = addr_reg;
        seq_next         = seq_reg;
        kind_next        = kind_reg;
        pend_next        = pend_reg;
        res_valid_next   = res_valid_reg && !res.ready;
        res_dup_next     = res_dup_reg;
        res_outcome_next = res_outcome_reg;
        tbl_wr           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pkt.valid)
                begin
                    addr_next       = pkt.src_addr;
                    seq_next        = pkt.seq_number;
                    kind_next       = pkt.kind;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    if (pkt.src_addr == own_addr_reg)
                    begin
                        pend_next  = OUTCOME_OWN;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (live)
                begin
                    tbl_wr.life_we  = 1'b1;
                    tbl_wr.life_val = hit ? life_reload_reg : tbl_rd.life - LIFE_W'(1);
                end
                if (!free_found_reg && free_here)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (hit)
                begin
                    tbl_wr.tag_we = !tag_eq;
                    pend_next     = tag_eq ? OUTCOME_DUP : OUTCOME_UPDATED;
                    state_next    = ST_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    if (free_found_reg || free_here)
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        pend_next  = OUTCOME_FULL;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_INSERT:
            begin
                tbl_wr.life_we  = 1'b1;
                tbl_wr.life_val = life_reload_reg;
                tbl_wr.tag_we   = 1'b1;
                tbl_wr.addr_we  = 1'b1;
                pend_next       = OUTCOME_INSERTED;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold the verdict until the result register is free.
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next   = 1'b1;
                    res_dup_next     = (pend_reg == OUTCOME_DUP);
                    res_outcome_next = pend_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            res_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
            free_found_reg <= free_found_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg    <= free_idx_next;
        addr_reg        <= addr_next;
        seq_reg         <= seq_next;
        kind_reg        <= kind_next;
        pend_reg        <= pend_next;
        res_dup_reg     <= res_dup_next;
        res_outcome_reg <= res_outcome_next;
    end

    assign pkt.ready        = (state_reg == ST_IDLE);
    assign res.valid        = res_valid_reg;
    assign res.is_duplicate = res_dup_reg;
    assign res.outcome      = res_outcome_reg;

endmodule

### rtl/dpf_entry_table.sv
// Cache entry storage: address, sequence and type per entry, plus lifetimes.
// One shared index for reading and writing. Depends on dpf_pkg.
module dpf_entry_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dpf_pkg::IDX_W-1:0]  idx,
    input  dpf_pkg::dpf_wr_t           wr,
    input  logic [dpf_pkg::ADDR_W-1:0] wr_addr,
    input  logic [dpf_pkg::SEQ_W-1:0]  wr_seq,
    input  logic [dpf_pkg::KIND_W-1:0] wr_kind,
    output dpf_pkg::dpf_entry_t        rd
);
    import dpf_pkg::*;

    logic [ADDR_W-1:0] addr_mem [ENTRIES];
    logic [SEQ_W-1:0]  seq_mem  [ENTRIES];
    logic [KIND_W-1:0] kind_mem [ENTRIES];
    logic [LIFE_W-1:0] life_reg [ENTRIES];

    // Lifetimes are cleared at reset, so every entry starts out free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                life_reg[i] <= '0;
            end
        end
        else if (wr.life_we)
        begin
            life_reg[idx] <= wr.life_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.addr_we)
        begin
            addr_mem[idx] <= wr_addr;
        end
        if (wr.tag_we)
        begin
            seq_mem[idx]  <= wr_seq;
            kind_mem[idx] <= wr_kind;
        end
    end

    assign rd.addr = addr_mem[idx];
    assign rd.seq  = seq_mem[idx];
    assign rd.kind = kind_mem[idx];
    assign rd.life = life_reg[idx];

endmodule

### rtl/dpf_checker.sv
// Port-level checks for the duplicate packet filter, bound to the top level.
// Watches the handshake and result signals of both channels. Depends on dpf_pkg.
module dpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pkt_valid,
    input logic       pkt_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic       res_is_duplicate,
    input logic [2:0] res_outcome
);
    import dpf_pkg::*;

    // A stalled result word keeps its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_is_duplicate)
            && $stable(res_outcome))
        else $error("result word changed while stalled");

    // One packet at a time: the filter is not ready in the cycle after an acceptance.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready |=> !pkt_ready)
        else $error("packet accepted on consecutive cycles");

    // The duplicate flag agrees with the outcome code.
    a_dup_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_is_duplicate == (res_outcome == OUTCOME_DUP)))
        else $error("duplicate flag disagrees with outcome");

    // Only defined outcome codes leave the block.
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_outcome == OUTCOME_OWN || res_outcome == OUTCOME_INSERTED
            || res_outcome == OUTCOME_UPDATED || res_outcome == OUTCOME_DUP
            || res_outcome == OUTCOME_FULL))
        else $error("undefined outcome code");

endmodule

bind duplicate_packet_filter_unit dpf_checker u_dpf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pkt_valid        (pkt.valid),
    .pkt_ready        (pkt.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_is_duplicate (res.is_duplicate),
    .res_outcome      (res.outcome)
);

### test/duplicate_packet_filter_unit_test.sv
// Self-checking testbench for duplicate_packet_filter_unit: drives packet headers and APB
// register writes, predicts each verdict word from its own model of the entry table and checks it.
// Depends on dpf_pkg, dpf_in_if, dpf_out_if and the filter RTL.
module duplicate_packet_filter_unit_test;
    import dpf_pkg::*;

    localparam int PAUSE_CYCLES = ENTRIES + 4;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [KIND_W-1:0] kind;
    } header_t;

    typedef struct {
        logic     is_duplicate;
        outcome_t outcome;
    } verdict_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    dpf_in_if  pkt_ch ();
    dpf_out_if res_ch ();

    duplicate_packet_filter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the configuration and of the entry table.
    logic [ADDR_W-1:0] cfg_own;
    logic [LIFE_W-1:0] cfg_reload;
    logic [ADDR_W-1:0] cache_addr [ENTRIES];
    logic [SEQ_W-1:0]  cache_seq  [ENTRIES];
    logic [KIND_W-1:0] cache_kind [ENTRIES];
    logic [LIFE_W-1:0] cache_life [ENTRIES];

    header_t  pending_headers [$];
    verdict_t expected_verdicts [$];
    int       failures;

    // Sender and receiver pacing.
    bit header_taken;
    int burst_left;
    int gap_left;
    int ready_mode;
    int ready_left;

    // Address pool for the random phases.
    logic [ADDR_W-1:0] addr_pool [64];
    logic [SEQ_W-1:0]  pool_seq  [64];
    logic [KIND_W-1:0] pool_kind [64];

    function automatic verdict_t filter_header(input header_t h);
        verdict_t v;
        int i;
        v.is_duplicate = 1'b0;
        v.outcome      = OUTCOME_OWN;
        if (h.addr == cfg_own)
            return v;
        // Live entries age as the walk passes them; the walk ends at the first address match.
        for (i = 0; i < ENTRIES; i++)
        begin
            if (cache_life[i] != 0)
            begin
                cache_life[i] = cache_life[i] - 1'b1;
                if (cache_addr[i] == h.addr)
                begin
                    cache_life[i] = cfg_reload;
                    if (cache_seq[i] == h.seq && cache_kind[i] == h.kind)
                    begin
                        v.is_duplicate = 1'b1;
                        v.outcome      = OUTCOME_DUP;
                        return v;
                    end
                    cache_seq[i]  = h.seq;
                    cache_kind[i] = h.kind;
                    v.outcome     = OUTCOME_UPDATED;
                    return v;
                end
            end
        end
        for (i = 0; i < ENTRIES; i++)
        begin
            if (cache_life[i] == 0)
            begin
                cache_addr[i] = h.addr;
                cache_seq[i]  = h.seq;
                cache_kind[i] = h.kind;
                cache_life[i] = cfg_reload;
                v.outcome     = OUTCOME_INSERTED;
                return v;
            end
        end
        v.outcome = OUTCOME_FULL;
        return v;
    endfunction

    always #5 clk = ~clk;

    // Acceptance of a header word: predict its verdict and retire it from the pending queue.
    always @(posedge clk)
    begin
        if (rst_n && pkt_ch.valid && pkt_ch.ready)
        begin
            expected_verdicts.push_back(filter_header(pending_headers.pop_front()));
            header_taken = 1'b1;
        end
    end

    // Header driver: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pkt_ch.valid <= 1'b0;
        end
        else if (!pkt_ch.valid || header_taken)
        begin
            header_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                pkt_ch.valid <= 1'b0;
            end
            else if (pending_headers.size() != 0)
            begin
                pkt_ch.valid      <= 1'b1;
                pkt_ch.src_addr   <= pending_headers[0].addr;
                pkt_ch.seq_number <= pending_headers[0].seq;
                pkt_ch.kind       <= pending_headers[0].kind;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 7))
                        0, 1:    gap_left = 0;
                        2:       gap_left = $urandom_range(20, 60);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                pkt_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: runs of full rate, random toggling and long stalls.
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 9);
            ready_left = (ready_mode >= 8) ? $urandom_range(1, 30) : $urandom_range(1, 50);
        end
        ready_left--;
        if (!rst_n || ready_mode <= 3)
            res_ch.ready <= 1'b1;
        else if (ready_mode <= 7)
            res_ch.ready <= 1'($urandom_range(0, 1));
        else
            res_ch.ready <= 1'b0;
    end

    // Verdict checker.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("unexpected verdict word: is_duplicate %0d, outcome %0d",
                       res_ch.is_duplicate, res_ch.outcome);
                failures++;
            end
            else
            begin
                verdict_t exp_v;
                exp_v = expected_verdicts.pop_front();
                if (res_ch.is_duplicate !== exp_v.is_duplicate)
                begin
                    $error("is_duplicate mismatch: expected %0d, actual %0d",
                           exp_v.is_duplicate, res_ch.is_duplicate);
                    failures++;
                end
                if (res_ch.outcome !== exp_v.outcome)
                begin
                    $error("outcome mismatch: expected %0d, actual %0d",
                           exp_v.outcome, res_ch.outcome);
                    failures++;
                end
            end
        end
    end

    // Writes a register over APB, reads it back and updates the shadow configuration.
    task automatic write_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] mask;
        mask = (idx == REG_LIFE_RELOAD) ? PDATA_W'({LIFE_W{1'b1}}) : PDATA_W'({ADDR_W{1'b1}});
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (value & mask))
        begin
            $error("prdata mismatch: expected %0h, actual %0h", value & mask, prdata & mask);
            failures++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_OWN_ADDR)
            cfg_own = value[ADDR_W-1:0];
        else
            cfg_reload = value[LIFE_W-1:0];
    endtask

    task automatic send_header(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq,
                               input logic [KIND_W-1:0] kind);
        header_t h;
        h.addr = addr;
        h.seq  = seq;
        h.kind = kind;
        pending_headers.push_back(h);
    endtask

    // Waits until every header has been taken and every verdict checked, then lets the
    // block settle before the configuration may change.
    task automatic drain();
        while (pending_headers.size() != 0 || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input logic [ADDR_W-1:0] own, input logic [LIFE_W-1:0] reload,
                                    input int pool_size, input int count);
        logic [ADDR_W-1:0] base;
        int n;
        int k;
        int pick;
        write_register(REG_OWN_ADDR, PDATA_W'(own));
        write_register(REG_LIFE_RELOAD, PDATA_W'(reload));
        base = $urandom;
        // Pool mixes near misses of one address, same-subnet neighbours, extremes and noise.
        for (k = 0; k < pool_size; k++)
        begin
            case ($urandom_range(0, 4))
                0:       addr_pool[k] = base ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
                1:       addr_pool[k] = {base[ADDR_W-1:8], 8'($urandom)};
                2:       addr_pool[k] = $urandom_range(0, 1) ? '1 : '0;
                default: addr_pool[k] = $urandom;
            endcase
            pool_seq[k]  = SEQ_W'($urandom);
            pool_kind[k] = KIND_W'($urandom);
        end
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_header(cfg_own, SEQ_W'($urandom), KIND_W'($urandom));
            end
            else if (pick < 14)
            begin
                send_header($urandom, SEQ_W'($urandom), KIND_W'($urandom));
            end
            else
            begin
                k = $urandom_range(0, pool_size - 1);
                case ($urandom_range(0, 5))
                    0, 1, 2: ;
                    3:       pool_seq[k] = SEQ_W'($urandom);
                    4:       pool_kind[k] = KIND_W'($urandom);
                    default:
                    begin
                        pool_seq[k]  = SEQ_W'($urandom);
                        pool_kind[k] = KIND_W'($urandom);
                    end
                endcase
                send_header(addr_pool[k], pool_seq[k], pool_kind[k]);
            end
        end
        drain();
    endtask

    initial
    begin
        int i;
        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pkt_ch.valid      = 1'b0;
        pkt_ch.src_addr   = '0;
        pkt_ch.seq_number = '0;
        pkt_ch.kind       = '0;
        res_ch.ready      = 1'b0;
        failures          = 0;
        header_taken      = 1'b0;
        burst_left        = 0;
        gap_left          = 0;
        ready_mode        = 0;
        ready_left        = 0;
        cfg_own           = '0;
        cfg_reload        = LIFE_RESET;
        for (i = 0; i < ENTRIES; i++)
        begin
            cache_addr[i] = '0;
            cache_seq[i]  = '0;
            cache_kind[i] = '0;
            cache_life[i] = '0;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset configuration: bypass of address zero, insert, update and duplicate.
        send_header('0, 8'h5A, 8'hA5);
        send_header('1, 8'h00, 8'h00);
        send_header('1, 8'h00, 8'h00);
        send_header('1, 8'hFF, 8'h00);
        send_header('1, 8'hFF, 8'hFF);
        send_header('1, 8'hFF, 8'hFF);
        send_header(32'h0000_0001, 8'h00, 8'h00);
        send_header(32'h0000_0001, 8'h00, 8'h01);
        send_header(32'h8000_0000, 8'h80, 8'h7F);
        drain();

        // Short lifetime: entries expire during the walk and are reused as free slots.
        write_register(REG_OWN_ADDR, '1);
        write_register(REG_LIFE_RELOAD, PDATA_W'(2));
        send_header('1, 8'h01, 8'h01);
        send_header('0, 8'hAA, 8'h55);
        send_header(32'h1234_5678, 8'h10, 8'h20);
        send_header(32'h1234_5679, 8'h10, 8'h20);
        send_header(32'h1234_567A, 8'h10, 8'h20);
        send_header(32'h1234_5679, 8'h10, 8'h20);
        send_header(32'h1234_5679, 8'h10, 8'h20);
        drain();

        // A reload of zero leaves every inserted or matched entry free at once.
        write_register(REG_LIFE_RELOAD, PDATA_W'(0));
        send_header(32'hCAFE_0001, 8'h01, 8'h02);
        send_header(32'hCAFE_0001, 8'h01, 8'h02);
        send_header(32'h1234_5679, 8'h10, 8'h20);
        drain();

        run_random_phase($urandom, 8'd255, 40, 300);
        run_random_phase('1, 8'd1, 8, 200);
        run_random_phase('0, 8'($urandom_range(3, 10)), 30, 300);
        run_random_phase($urandom, LIFE_RESET, 20, 300);
        run_random_phase($urandom, 8'd30, 60, 300);
        run_random_phase($urandom, 8'd255, 12, 200);

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/dpf_pkg.sv
rtl/dpf_in_if.sv
rtl/dpf_out_if.sv
rtl/dpf_entry_table.sv
rtl/duplicate_packet_filter_unit.sv
rtl/dpf_checker.sv
test/duplicate_packet_filter_unit_test.sv
